FILE: design/bitmap_slot_allocator_top_macros.svh
// assertion macros for the bitmap slot allocator
// used by bitmap_slot_allocator_top only; no other dependencies
`ifndef BITMAP_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, skipped while reset is low
`define BSA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bsa assertion failed");

// next-cycle implication, skipped while reset is low
`define BSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bsa assertion failed");

`endif

FILE: design/bsa_pkg.sv
// shared types, request codes and helpers for the bitmap slot allocator
// no dependencies
package bsa_pkg;

    localparam int BSA_MAP_BYTES = 16;

    localparam logic [7:0] BYTE_FULL  = 8'hFF;
    localparam logic [7:0] BYTE_EMPTY = 8'h00;

    localparam logic [2:0] REQ_WRITE     = 3'd0;
    localparam logic [2:0] REQ_CLEAR     = 3'd1;
    localparam logic [2:0] REQ_READ      = 3'd2;
    localparam logic [2:0] REQ_FIND      = 3'd3;
    localparam logic [2:0] REQ_FULL      = 3'd4;
    localparam logic [2:0] REQ_CLEAR_ALL = 3'd5;

    typedef struct packed {
        logic [2:0] req_type;
        logic [6:0] slot_index;
        logic       set_value;
    } t_in;

    typedef struct packed {
        logic       bit_value;
        logic [6:0] free_index;
        logic       found;
        logic       all_taken;
    } t_out;

    // position of the lowest clear bit; only meaningful when the byte is not full
    function automatic logic [2:0] first_zero(input logic [7:0] b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (!b[k]) begin
                pos = 3'(k);
            end
        end
        return pos;
    endfunction

endpackage

FILE: design/bitmap_slot_allocator_top.sv
// Bitmap slot allocator, top level. Requests come in on the in channel (valid/ready,
// payload t_in) and one result beat per request leaves on the out channel (t_out).
// Request kinds: write bit, clear bit, read bit, find lowest free slot from the hint
// byte upward, full query, clear all. A find that succeeds moves the hint to the slot
// it reports; it never marks the slot as used.
// One request is in work at a time. What each request does before its result beat:
//   write, clear: one read-modify-write of the byte; read: one read of the byte
//   find: a scan of bytes from the hint byte; full query: a scan of bytes from byte 0
//   clear all: a sweep of every byte; unused codes and out-of-range slots: no access
// Scans use the one read port and sweeps the one write port, one byte per cycle.
// After reset a clearing sweep writes every byte to zero, and in_ready stays low
// until it is done. The output register lets the sequencer start the next request
// while a result beat waits; a stalled receiver holds the sequencer only when it
// has a second result ready.
// depends on bsa_pkg, bsa_ctrl, bsa_mem and bitmap_slot_allocator_top_macros.svh
`include "bitmap_slot_allocator_top_macros.svh"

module bitmap_slot_allocator_top
    import bsa_pkg::*;
#(
    parameter int MAP_BYTES = BSA_MAP_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic w_res_valid;
    logic w_res_ready;
    t_out w_res;
    logic r_out_valid;
    t_out r_out;

    bsa_ctrl #(
        .MAP_BYTES(MAP_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_in_valid),
        .o_req_ready(o_in_ready),
        .i_req      (i_in),
        .o_res_valid(w_res_valid),
        .i_res_ready(w_res_ready),
        .o_res      (w_res)
    );

    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a found slot never comes with a read bit or a full flag
    `BSA_ASSERT_IMPL(a_found_alone, i_clk, i_rst_n, o_out_valid && o_out.found, !o_out.all_taken && !o_out.bit_value)
    // a result handed over always shows up on the out channel
    `BSA_ASSERT_NEXT(a_res_loaded, i_clk, i_rst_n, w_res_valid && w_res_ready, o_out_valid)
    // the sequencer leaves idle after every accepted beat
    `BSA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

FILE: design/bsa_mem.sv
// byte-wide bitmap storage: one write port, one read port, registered read data
// depends on nothing but its parameters
module bsa_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/bsa_ctrl.sv
// request sequencer: read-modify-write, byte scans and clearing sweeps over bsa_mem
// depends on bsa_pkg and bsa_mem
module bsa_ctrl
    import bsa_pkg::*;
#(
    parameter int MAP_BYTES = BSA_MAP_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_in  i_req,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_out o_res
);

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CW = $clog2(MAP_BYTES + 1);

    typedef enum logic [5:0] {
        ST_INIT = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_RMW  = 6'b000100,
        ST_SCAN = 6'b001000,
        ST_CLR  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_scan,  n_scan;
    logic [6:0]    r_hint,  n_hint;
    t_in           r_req,   n_req;
    t_out          r_res,   n_res;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;

    logic          w_slot_ok;
    logic          w_hint_ok;
    logic          w_last;
    logic [CW-1:0] w_scan_inc;
    logic [7:0]    w_mask;
    logic [6:0]    w_free;

    bsa_mem #(
        .DEPTH(MAP_BYTES),
        .AW   (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_slot_ok  = 32'(i_req.slot_index[6:3]) < 32'(MAP_BYTES);
    assign w_hint_ok  = 32'(r_hint[6:3]) < 32'(MAP_BYTES);
    assign w_last     = (r_scan == CW'(MAP_BYTES - 1));
    assign w_scan_inc = r_scan + CW'(1);
    assign w_mask     = 8'(1) << r_req.slot_index[2:0];
    // slot number wraps to 7 bits on maps wider than 16 bytes
    assign w_free     = {4'(r_scan), first_zero(w_rdata)};

    always_comb begin
        n_state = r_state;
        n_scan  = r_scan;
        n_hint  = r_hint;
        n_req   = r_req;
        n_res   = r_res;
        w_we    = 1'b0;
        w_waddr = r_scan[AW-1:0];
        w_wdata = BYTE_EMPTY;
        w_re    = 1'b0;
        w_raddr = AW'(i_req.slot_index[6:3]);
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_req = i_req;
                    n_res = '0;
                    case (i_req.req_type)
                        REQ_WRITE, REQ_CLEAR, REQ_READ: begin
                            if (w_slot_ok) begin
                                w_re    = 1'b1;
                                n_state = ST_RMW;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        REQ_FIND: begin
                            if (w_hint_ok) begin
                                w_re    = 1'b1;
                                w_raddr = AW'(r_hint[6:3]);
                                n_scan  = CW'(r_hint[6:3]);
                                n_state = ST_SCAN;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        REQ_FULL: begin
                            w_re    = 1'b1;
                            w_raddr = '0;
                            n_scan  = '0;
                            n_state = ST_SCAN;
                        end
                        REQ_CLEAR_ALL: begin
                            n_scan  = '0;
                            n_state = ST_CLR;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RMW: begin
                // the byte was read last cycle; no other access can touch it meanwhile
                w_waddr = AW'(r_req.slot_index[6:3]);
                if (r_req.req_type == REQ_READ) begin
                    n_res.bit_value = w_rdata[r_req.slot_index[2:0]];
                end else begin
                    w_we = 1'b1;
                    if (r_req.req_type == REQ_WRITE && r_req.set_value) begin
                        w_wdata = w_rdata | w_mask;
                    end else begin
                        w_wdata = w_rdata & ~w_mask;
                    end
                end
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                if (w_rdata != BYTE_FULL) begin
                    if (r_req.req_type == REQ_FIND) begin
                        n_res.found      = 1'b1;
                        n_res.free_index = w_free;
                        n_hint           = w_free;
                    end
                    n_state = ST_DONE;
                end else if (w_last) begin
                    n_res.all_taken = (r_req.req_type == REQ_FULL);
                    n_state         = ST_DONE;
                end else begin
                    // next byte read overlaps the check of this one
                    w_re    = 1'b1;
                    w_raddr = w_scan_inc[AW-1:0];
                    n_scan  = w_scan_inc;
                end
            end
            ST_INIT, ST_CLR: begin
                w_we = 1'b1;
                if (w_last) begin
                    n_state = (r_state == ST_INIT) ? ST_IDLE : ST_DONE;
                end else begin
                    n_scan = w_scan_inc;
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
                n_scan  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_scan  <= '0;
            r_hint  <= '0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
            r_hint  <= n_hint;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule
